FILE: src/prpe_pkg.sv
// ----------------------------------------------------------------------------
// prpe_pkg: shared types and tables for the profile record encoder
// Message kinds, byte sequencer tokens, controller/datapath command and
// status structs, and the per-kind token table.
// ----------------------------------------------------------------------------
package prpe_pkg;

  localparam int unsigned VAL_W          = 64;
  localparam int unsigned VLEN_W         = 4;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned LEN_W          = 6;
  localparam int unsigned VAR_GROUPS     = 10;
  localparam int unsigned FUNC_INNER_MAX = 32;

  localparam logic [7:0] TAG_F1_VARINT = 8'h08;
  localparam logic [7:0] TAG_F2_VARINT = 8'h10;
  localparam logic [7:0] TAG_F3_VARINT = 8'h18;
  localparam logic [7:0] TAG_F1_LEN    = 8'h0A;
  localparam logic [7:0] TAG_F2_LEN    = 8'h12;
  localparam logic [7:0] TAG_F4_LEN    = 8'h22;
  localparam logic [7:0] TAG_F5_LEN    = 8'h2A;

  typedef enum logic [1:0] {
    OP_VALUE_TYPE = 2'd0,
    OP_SAMPLE     = 2'd1,
    OP_LOCATION   = 2'd2,
    OP_FUNCTION   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    TK_CONST,
    TK_LEN_OUTER,
    TK_LEN_A,
    TK_LEN_BC,
    TK_LEN_LINE,
    TK_VAR_A,
    TK_VAR_B,
    TK_VAR_C,
    TK_END
  } tk_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    tk_e        tk;
    logic [7:0] cbyte;
  } tok_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic ovf;
    logic next_end;
    tok_t tok;
  } cmd_t;

  typedef struct packed {
    op_e  kind;
    logic ovf_cond;
    logic cont;
    logic out_free;
  } sts_t;

  // varint byte count of a 64-bit value, 1 to 10
  function automatic logic [VLEN_W-1:0] vlen(input logic [VAL_W-1:0] v);
    logic [VLEN_W-1:0] l;
    l = VLEN_W'(1);
    for (int g = 1; g < VAR_GROUPS; g++) begin
      if ((v >> (7 * g)) != '0) l = VLEN_W'(g + 1);
    end
    return l;
  endfunction

  function automatic tok_t mk(input tk_e tk, input logic [7:0] b);
    tok_t t;
    t.tk    = tk;
    t.cbyte = b;
    return t;
  endfunction

  function automatic tok_t tok_at(input op_e kind, input logic [STEP_W-1:0] step);
    tok_t t;
    t = mk(TK_END, 8'h00);
    case (kind)
      OP_VALUE_TYPE: begin
        case (step)
          4'd0: t = mk(TK_CONST, TAG_F1_LEN);
          4'd1: t = mk(TK_LEN_OUTER, 8'h00);
          4'd2: t = mk(TK_CONST, TAG_F1_VARINT);
          4'd3: t = mk(TK_VAR_A, 8'h00);
          4'd4: t = mk(TK_CONST, TAG_F2_VARINT);
          4'd5: t = mk(TK_VAR_B, 8'h00);
          default: t = mk(TK_END, 8'h00);
        endcase
      end
      OP_SAMPLE: begin
        case (step)
          4'd0: t = mk(TK_CONST, TAG_F2_LEN);
          4'd1: t = mk(TK_LEN_OUTER, 8'h00);
          4'd2: t = mk(TK_CONST, TAG_F1_LEN);
          4'd3: t = mk(TK_LEN_A, 8'h00);
          4'd4: t = mk(TK_VAR_A, 8'h00);
          4'd5: t = mk(TK_CONST, TAG_F2_LEN);
          4'd6: t = mk(TK_LEN_BC, 8'h00);
          4'd7: t = mk(TK_VAR_B, 8'h00);
          4'd8: t = mk(TK_VAR_C, 8'h00);
          default: t = mk(TK_END, 8'h00);
        endcase
      end
      OP_LOCATION: begin
        case (step)
          4'd0: t = mk(TK_CONST, TAG_F4_LEN);
          4'd1: t = mk(TK_LEN_OUTER, 8'h00);
          4'd2: t = mk(TK_CONST, TAG_F1_VARINT);
          4'd3: t = mk(TK_VAR_A, 8'h00);
          4'd4: t = mk(TK_CONST, TAG_F4_LEN);
          4'd5: t = mk(TK_LEN_LINE, 8'h00);
          4'd6: t = mk(TK_CONST, TAG_F1_VARINT);
          4'd7: t = mk(TK_VAR_B, 8'h00);
          default: t = mk(TK_END, 8'h00);
        endcase
      end
      OP_FUNCTION: begin
        case (step)
          4'd0: t = mk(TK_CONST, TAG_F5_LEN);
          4'd1: t = mk(TK_LEN_OUTER, 8'h00);
          4'd2: t = mk(TK_CONST, TAG_F1_VARINT);
          4'd3: t = mk(TK_VAR_A, 8'h00);
          4'd4: t = mk(TK_CONST, TAG_F2_VARINT);
          4'd5: t = mk(TK_VAR_B, 8'h00);
          4'd6: t = mk(TK_CONST, TAG_F3_VARINT);
          4'd7: t = mk(TK_VAR_B, 8'h00);
          default: t = mk(TK_END, 8'h00);
        endcase
      end
      default: t = mk(TK_END, 8'h00);
    endcase
    return t;
  endfunction

endpackage

FILE: src/prpe_ctrl.sv
// ----------------------------------------------------------------------------
// prpe_ctrl: record sequencer
// Walks the per-kind token list, one output byte per cycle while the output
// is free, and tells the datapath when to load a record and when to emit.
// ----------------------------------------------------------------------------
module prpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prpe_pkg::sts_t  sts_i,
  output prpe_pkg::cmd_t  cmd_o
);

  prpe_pkg::state_e                state_q, state_d;
  logic [prpe_pkg::STEP_W-1:0]     step_q, step_d;
  logic [prpe_pkg::STEP_W-1:0]     step_nx;
  prpe_pkg::tok_t                  tok, tok_nx;

  assign step_nx = step_q + prpe_pkg::STEP_W'(1);
  assign tok     = prpe_pkg::tok_at(sts_i.kind, step_q);
  assign tok_nx  = prpe_pkg::tok_at(sts_i.kind, step_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prpe_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      prpe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = prpe_pkg::ST_EMIT;
          step_d  = '0;
        end
      end
      prpe_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.ovf_cond) begin
            state_d = prpe_pkg::ST_IDLE;
          end else if (!sts_i.cont) begin
            step_d = step_nx;
            if (tok_nx.tk == prpe_pkg::TK_END) state_d = prpe_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = prpe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.ovf      = 1'b0;
    cmd_o.next_end = tok_nx.tk == prpe_pkg::TK_END;
    cmd_o.tok      = tok;
    case (state_q)
      prpe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      prpe_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.ovf  = sts_i.ovf_cond;
      end
      default: ;
    endcase
  end

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == prpe_pkg::ST_EMIT && step_q == '0))
    else $error("record load did not start the sequence");

  a_no_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prpe_pkg::ST_EMIT |-> tok.tk != prpe_pkg::TK_END)
    else $error("sequencer ran past the end of the token list");

  a_ovf_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.ovf) |=> state_q == prpe_pkg::ST_IDLE)
    else $error("overflow record emitted more than one result");

endmodule

FILE: src/prpe_datapath.sv
// ----------------------------------------------------------------------------
// prpe_datapath: record registers, varint shifter and output register
// Holds the record and its varint lengths, works out the field lengths, and
// builds one wire byte per emit command.
// ----------------------------------------------------------------------------
module prpe_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   op_i,
  input  logic [prpe_pkg::VAL_W-1:0]   val_a_i,
  input  logic [prpe_pkg::VAL_W-1:0]   val_b_i,
  input  logic [prpe_pkg::VAL_W-1:0]   val_c_i,
  input  prpe_pkg::cmd_t               cmd_i,
  output prpe_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         out_last_o,
  output logic                         out_ovf_o
);

  localparam int unsigned VW = prpe_pkg::VAL_W;
  localparam int unsigned LW = prpe_pkg::VLEN_W;
  localparam int unsigned NW = prpe_pkg::LEN_W;

  prpe_pkg::op_e   kind_q;
  logic [VW-1:0]   a_q, b_q, c_q, sh_q, sh_d;
  logic [LW-1:0]   la_q, lb_q, lc_q, cnt_q, cnt_d;
  logic [7:0]      obyte_q;
  logic            olast_q, oovf_q, ovalid_q;

  logic [NW-1:0]   outer_len, func_len;
  logic [VW-1:0]   sel_val, src;
  logic [LW-1:0]   sel_len, rem;
  logic            is_var, cont;
  logic [7:0]      ebyte;

  assign func_len = NW'(3) + NW'(la_q) + NW'(lb_q) + NW'(lb_q);

  always_comb begin
    case (kind_q)
      prpe_pkg::OP_VALUE_TYPE: outer_len = NW'(2) + NW'(la_q) + NW'(lb_q);
      prpe_pkg::OP_SAMPLE:     outer_len = NW'(4) + NW'(la_q) + NW'(lb_q) + NW'(lc_q);
      prpe_pkg::OP_LOCATION:   outer_len = NW'(4) + NW'(la_q) + NW'(lb_q);
      default:                 outer_len = func_len;
    endcase
  end

  always_comb begin
    is_var  = 1'b0;
    sel_len = LW'(1);
    sel_val = '0;
    case (cmd_i.tok.tk)
      prpe_pkg::TK_CONST:     sel_val = VW'(cmd_i.tok.cbyte);
      prpe_pkg::TK_LEN_OUTER: sel_val = VW'(outer_len);
      prpe_pkg::TK_LEN_A:     sel_val = VW'(la_q);
      prpe_pkg::TK_LEN_BC:    sel_val = VW'(NW'(lb_q) + NW'(lc_q));
      prpe_pkg::TK_LEN_LINE:  sel_val = VW'(NW'(lb_q) + NW'(1));
      prpe_pkg::TK_VAR_A: begin
        is_var  = 1'b1;
        sel_val = a_q;
        sel_len = la_q;
      end
      prpe_pkg::TK_VAR_B: begin
        is_var  = 1'b1;
        sel_val = b_q;
        sel_len = lb_q;
      end
      prpe_pkg::TK_VAR_C: begin
        is_var  = 1'b1;
        sel_val = c_q;
        sel_len = lc_q;
      end
      default: ;
    endcase
  end

  // cnt_q != 0: in the middle of a multi-byte varint
  assign src   = (cnt_q != '0) ? sh_q : sel_val;
  assign rem   = (cnt_q != '0) ? cnt_q : sel_len;
  assign cont  = rem > LW'(1);
  assign ebyte = is_var ? {cont, src[6:0]} : src[7:0];
  assign sh_d  = src >> 7;
  assign cnt_d = rem - LW'(1);

  assign sts_o.kind     = kind_q;
  assign sts_o.ovf_cond = (kind_q == prpe_pkg::OP_FUNCTION) &&
                          (func_len > NW'(prpe_pkg::FUNC_INNER_MAX));
  assign sts_o.cont     = cont;
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.emit && !cmd_i.ovf) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= prpe_pkg::op_e'(op_i);
      a_q    <= val_a_i;
      b_q    <= val_b_i;
      c_q    <= val_c_i;
      la_q   <= prpe_pkg::vlen(val_a_i);
      lb_q   <= prpe_pkg::vlen(val_b_i);
      lc_q   <= prpe_pkg::vlen(val_c_i);
    end
    if (cmd_i.emit) begin
      sh_q <= sh_d;
      if (cmd_i.ovf) begin
        obyte_q <= 8'h00;
        olast_q <= 1'b1;
        oovf_q  <= 1'b1;
      end else begin
        obyte_q <= ebyte;
        olast_q <= cmd_i.next_end && !cont;
        oovf_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_ovf_o   = oovf_q;

  a_cont_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !cmd_i.ovf && cont) |=> cnt_q != '0)
    else $error("varint continuation lost its byte count");

endmodule

FILE: src/profile_record_protobuf_encoder.sv
// ----------------------------------------------------------------------------
// profile_record_protobuf_encoder: protobuf wire encoder for profile records
// Turns one record (kind in tuser, three 64-bit values in tdata) into the
// bytes of one length-delimited submessage, one byte per output request.
// ----------------------------------------------------------------------------
// A record is accepted only while the encoder is idle; it then emits one
// byte per cycle from its output register while the output is free; a
// record gives 6 to 36 bytes (a dropped Function record gives a single
// overflow request), produced by the byte sequencer that walks the token
// list one byte at a time. Output stalls hold the sequencer. tlast marks
// the final byte of a record; tuser[0] flags a dropped Function record
// whose inner part would exceed 32 bytes.
module profile_record_protobuf_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // value_a[63:0], value_b[127:64], value_c[191:128]
  input  logic [1:0]   s_axis_tuser,   // operation[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // out_byte[7:0]
  output logic         m_axis_tlast,   // last
  output logic [0:0]   m_axis_tuser    // overflow[0]
);

  prpe_pkg::cmd_t cmd;
  prpe_pkg::sts_t sts;
  logic           ovf;

  prpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prpe_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tuser),
    .val_a_i     (s_axis_tdata[63:0]),
    .val_b_i     (s_axis_tdata[127:64]),
    .val_c_i     (s_axis_tdata[191:128]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (ovf)
  );

  assign m_axis_tuser = ovf;

endmodule

FILE: tb/sv/tb_profile_record_protobuf_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_profile_record_protobuf_encoder: self-checking bench for the encoder
// Sends records of every kind and predicts the submessage bytes of each one
// (tags, varint lengths, nested parts, the Function overflow drop). Output
// bytes are checked in order against the prediction. The sender and the
// receiver idle at random in the directed phase and two random phases.
// ----------------------------------------------------------------------------
module tb_profile_record_protobuf_encoder;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_GAP       = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } wire_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;   // value_a[63:0], value_b[127:64], value_c[191:128]
  logic [1:0]   s_axis_tuser = '0;   // operation[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;        // out_byte[7:0]
  logic         m_axis_tlast;        // last
  logic [0:0]   m_axis_tuser;        // overflow[0]

  // signals sampled mid-cycle, acted on at the next rising edge
  logic         in_fire_q = 1'b0;
  logic         out_fire_q = 1'b0;
  logic [7:0]   out_data_q;
  logic         out_last_q;
  logic         out_ovf_q;

  wire_byte_t   bytes_due[$];
  logic [7:0]   frame_bytes[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  fail_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;

  profile_record_protobuf_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    in_fire_q  = s_axis_tvalid & s_axis_tready;
    out_fire_q = m_axis_tvalid & m_axis_tready;
    out_data_q = m_axis_tdata;
    out_last_q = m_axis_tlast;
    out_ovf_q  = m_axis_tuser[0];
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---- predictor ----

  function automatic int unsigned varint_len(input logic [63:0] v);
    int unsigned n;
    n = 1;
    while (v >= 64'd128) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  function automatic void put_varint(input logic [63:0] v);
    while (v >= 64'd128) begin
      frame_bytes.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    frame_bytes.push_back({1'b0, v[6:0]});
  endfunction

  function automatic void predict_record(input prpe_pkg::op_e kind, input logic [63:0] a,
                                         input logic [63:0] b, input logic [63:0] c);
    int unsigned inner;
    int unsigned part_a;
    int unsigned part_bc;
    wire_byte_t  wb;
    frame_bytes.delete();
    case (kind)
      prpe_pkg::OP_VALUE_TYPE: begin
        inner = 2 + varint_len(a) + varint_len(b);
        frame_bytes.push_back(prpe_pkg::TAG_F1_LEN);
        put_varint(64'(inner));
        frame_bytes.push_back(prpe_pkg::TAG_F1_VARINT);
        put_varint(a);
        frame_bytes.push_back(prpe_pkg::TAG_F2_VARINT);
        put_varint(b);
      end
      prpe_pkg::OP_SAMPLE: begin
        part_a  = varint_len(a);
        part_bc = varint_len(b) + varint_len(c);
        inner   = 2 + varint_len(64'(part_a)) + part_a + varint_len(64'(part_bc)) + part_bc;
        frame_bytes.push_back(prpe_pkg::TAG_F2_LEN);
        put_varint(64'(inner));
        frame_bytes.push_back(prpe_pkg::TAG_F1_LEN);
        put_varint(64'(part_a));
        put_varint(a);
        frame_bytes.push_back(prpe_pkg::TAG_F2_LEN);
        put_varint(64'(part_bc));
        put_varint(b);
        put_varint(c);
      end
      prpe_pkg::OP_LOCATION: begin
        part_a = 1 + varint_len(b);   // nested Line
        inner  = 2 + varint_len(a) + varint_len(64'(part_a)) + part_a;
        frame_bytes.push_back(prpe_pkg::TAG_F4_LEN);
        put_varint(64'(inner));
        frame_bytes.push_back(prpe_pkg::TAG_F1_VARINT);
        put_varint(a);
        frame_bytes.push_back(prpe_pkg::TAG_F4_LEN);
        put_varint(64'(part_a));
        frame_bytes.push_back(prpe_pkg::TAG_F1_VARINT);
        put_varint(b);
      end
      default: begin
        inner = 3 + varint_len(a) + 2 * varint_len(b);
        if (inner > prpe_pkg::FUNC_INNER_MAX) begin
          wb.data = 8'h00;
          wb.last = 1'b1;
          wb.ovf  = 1'b1;
          bytes_due.push_back(wb);
          return;
        end
        frame_bytes.push_back(prpe_pkg::TAG_F5_LEN);
        put_varint(64'(inner));
        frame_bytes.push_back(prpe_pkg::TAG_F1_VARINT);
        put_varint(a);
        frame_bytes.push_back(prpe_pkg::TAG_F2_VARINT);
        put_varint(b);
        frame_bytes.push_back(prpe_pkg::TAG_F3_VARINT);
        put_varint(b);
      end
    endcase
    foreach (frame_bytes[i]) begin
      wb.data = frame_bytes[i];
      wb.last = (i == frame_bytes.size() - 1);
      wb.ovf  = 1'b0;
      bytes_due.push_back(wb);
    end
  endfunction

  // ---- result checker and watchdog ----

  always @(posedge clk_i) begin
    wire_byte_t want;
    if (out_fire_q) begin
      if (bytes_due.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected byte %02h last %0b ovf %0b", out_data_q, out_last_q, out_ovf_q);
      end else begin
        want = bytes_due.pop_front();
        if (want.data !== out_data_q || want.last !== out_last_q || want.ovf !== out_ovf_q) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("byte mismatch: expected %02h last %0b ovf %0b, got %02h last %0b ovf %0b",
                     want.data, want.last, want.ovf, out_data_q, out_last_q, out_ovf_q);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire_q || out_fire_q) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- stimulus ----

  task automatic send_record(input prpe_pkg::op_e kind, input logic [63:0] a,
                             input logic [63:0] b, input logic [63:0] c);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!in_fire_q);
    predict_record(kind, a, b, c);
  endtask

  // sender holds off until every predicted byte is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int unsigned width;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v[63] = 1'b1;
      3: begin
        width = $urandom_range(1, 14);
        v = v & ((64'd1 << width) - 64'd1);
      end
      default: begin
        width = $urandom_range(1, 64);
        if (width < 64) v = v & ((64'd1 << width) - 64'd1);
      end
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_record(prpe_pkg::OP_VALUE_TYPE, 64'd0, 64'd0, 64'd0);
    send_record(prpe_pkg::OP_VALUE_TYPE, ones, ones, ones);
    send_record(prpe_pkg::OP_VALUE_TYPE, 64'd127, 64'd128, 64'd0);
    send_record(prpe_pkg::OP_SAMPLE, 64'd0, 64'd0, 64'd0);
    send_record(prpe_pkg::OP_SAMPLE, ones, ones, ones);
    send_record(prpe_pkg::OP_SAMPLE, 64'd128, 64'd127, 64'h8000_0000_0000_0000);
    send_record(prpe_pkg::OP_SAMPLE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'd16383);
    send_record(prpe_pkg::OP_LOCATION, 64'd0, 64'd0, ones);
    send_record(prpe_pkg::OP_LOCATION, ones, ones, 64'd0);
    send_record(prpe_pkg::OP_LOCATION, 64'd300, 64'd16384, 64'd7);
    send_record(prpe_pkg::OP_FUNCTION, 64'd0, 64'd0, 64'd0);
    // both varints ten bytes: inner part too long, record dropped
    send_record(prpe_pkg::OP_FUNCTION, ones, ones, 64'd0);
    send_record(prpe_pkg::OP_FUNCTION, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                ones);
    // inner part exactly at the limit
    send_record(prpe_pkg::OP_FUNCTION, 64'h7FFF_FFFF_FFFF_FFFF, ones, 64'd0);
    send_record(prpe_pkg::OP_FUNCTION, ones, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    send_record(prpe_pkg::OP_FUNCTION, 64'd1, ones, 64'd0);
    send_record(prpe_pkg::OP_FUNCTION, ones, 64'd1, 64'd0);
    send_record(prpe_pkg::OP_FUNCTION, 64'd0, 64'h8000_0000_0000_0000, 64'd0);
    send_record(prpe_pkg::OP_VALUE_TYPE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'd0);
    send_record(prpe_pkg::OP_LOCATION, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'd0);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_record(prpe_pkg::op_e'($urandom_range(3)), rand_value(), rand_value(),
                  rand_value());
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 25;
    recv_stall_pct = 59;
    test_directed();
    test_random(85, 25, 59);
    test_random(85, 59, 25);
    test_random(85, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bytes_due.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/prpe_pkg.sv
src/prpe_ctrl.sv
src/prpe_datapath.sv
src/profile_record_protobuf_encoder.sv
tb/sv/tb_profile_record_protobuf_encoder.sv
